/* hw/rtl/socks_pkg.sv */
// shared types, codes and byte-sequence helpers for the socks5 connect handshake core
// no dependencies; imported by every module of the block

package socks_pkg;

   // queue depth between the protocol front and the byte serializer
   localparam int QUEUE_DEPTH = 4;

   // action codes of a request transaction
   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_BYTE  = 2'd1;
   localparam logic [1:0] ACT_CLOSE = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_TX    = 2'd0;
   localparam logic [1:0] KIND_READY = 2'd1;
   localparam logic [1:0] KIND_FAIL  = 2'd2;

   // protocol bytes
   localparam logic [7:0] SOCKS_VER   = 8'd5;
   localparam logic [7:0] NUM_METHODS = 8'd1;
   localparam logic [7:0] METHOD_NONE = 8'd0;
   localparam logic [7:0] CMD_CONNECT = 8'd1;
   localparam logic [7:0] RSV_BYTE    = 8'd0;
   localparam logic [7:0] STATUS_OK   = 8'd0;
   localparam logic [7:0] ATYP_IPV4   = 8'd1;
   localparam logic [7:0] ATYP_NAME   = 8'd3;
   localparam logic [7:0] ATYP_IPV6   = 8'd4;

   // bound address lengths including the port
   localparam logic [8:0] SKIP_IPV4 = 9'd6;
   localparam logic [8:0] SKIP_IPV6 = 9'd18;
   localparam logic [8:0] PORT_LEN  = 9'd2;

   // longest byte run and its index width
   localparam int          MAX_RUN   = 22;
   localparam logic [4:0]  LEN_GREET = 5'd3;
   localparam logic [4:0]  LEN_REQ4  = 5'd10;
   localparam logic [4:0]  LEN_REQ6  = 5'd22;
   localparam logic [4:0]  LEN_ONE   = 5'd1;
   localparam logic [4:0]  LAST_POS  = 5'd21;

   typedef struct packed {
      logic [1:0]  action;
      logic        address_family;
      logic [63:0] dest_addr_high;
      logic [63:0] dest_addr_low;
      logic [15:0] dest_port;
      logic [7:0]  rx_byte;
   } req_type;

   typedef struct packed {
      logic [1:0] out_kind;
      logic [7:0] tx_byte;
      logic       last_of_run;
   } rsp_type;

   // handshake phases of the front
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_METHOD,
      PH_HEAD,
      PH_NAMELEN,
      PH_SKIP,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      JOB_GREET,
      JOB_REQUEST,
      JOB_READY,
      JOB_FAIL
   } job_kind_type;

   // one unit of work handed from front to back
   typedef struct packed {
      job_kind_type kind;
      logic         family;
      logic [63:0]  addr_high;
      logic [63:0]  addr_low;
      logic [15:0]  port;
   } job_type;

   // number of results a job produces
   function automatic logic [4:0] job_len(job_type j);
      logic [4:0] len;
      case (j.kind)
         JOB_GREET:   len = LEN_GREET;
         JOB_REQUEST: len = j.family ? LEN_REQ6 : LEN_REQ4;
         default:     len = LEN_ONE;
      endcase
      return len;
   endfunction

   // transmit byte at position idx of a job, first byte at the top of the sequence
   function automatic logic [7:0] job_byte(job_type j, logic [4:0] idx);
      logic [175:0] seq;
      logic [4:0]   pos;
      seq = '0;
      case (j.kind)
         JOB_GREET: begin
            seq = {SOCKS_VER, NUM_METHODS, METHOD_NONE, 152'd0};
         end
         JOB_REQUEST: begin
            if (j.family) begin
               seq = {SOCKS_VER, CMD_CONNECT, RSV_BYTE, ATYP_IPV6,
                      j.addr_high, j.addr_low, j.port};
            end else begin
               seq = {SOCKS_VER, CMD_CONNECT, RSV_BYTE, ATYP_IPV4,
                      j.addr_low[31:0], j.port, 96'd0};
            end
         end
         default: begin
            seq = '0;
         end
      endcase
      pos = LAST_POS - idx;
      return seq[{pos, 3'b000} +: 8];
   endfunction

endpackage

/* hw/rtl/socks_queue.sv */
// small job queue between the protocol front and the byte serializer
// depends on socks_pkg for the job type

module socks_queue
   import socks_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type pop_job,
   output logic    empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_job = slot_ff[rd_ptr_ff];

   // pointer and fill tracking
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage write
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("job pushed into a full queue");
   assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("job popped from an empty queue");

endmodule

/* hw/rtl/socks_front.sv */
// protocol front: accepts request transactions, checks proxy replies, queues jobs
// depends on socks_pkg for codes, phases and the job type

module socks_front
   import socks_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    push,
   output job_type push_job,
   input  logic    q_full
);

   phase_type   phase_ff, phase_in;
   logic [1:0]  count_ff, count_in;
   logic [8:0]  skip_ff, skip_in;
   logic [8:0]  skip_dec;
   logic        family_ff;
   logic [63:0] addr_high_ff;
   logic [63:0] addr_low_ff;
   logic [15:0] port_ff;
   logic        fire;
   logic        in_hs;
   logic [7:0]  rx;

   assign req_ready = !q_full;
   assign fire      = req_valid && req_ready;
   assign rx        = req_data.rx_byte;
   assign in_hs     = (phase_ff inside {PH_METHOD, PH_HEAD, PH_NAMELEN, PH_SKIP});
   assign skip_dec  = (skip_ff != '0) ? skip_ff - 1'b1 : skip_ff;

   // next state
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      skip_in  = skip_ff;
      if (fire) begin
         case (req_data.action)
            ACT_START: begin
               phase_in = PH_METHOD;
               count_in = '0;
               skip_in  = '0;
            end
            ACT_CLOSE: begin
               if (in_hs) begin
                  phase_in = PH_DONE;
               end
            end
            ACT_BYTE: begin
               case (phase_ff)
                  PH_METHOD: begin
                     if (count_ff == 2'd0) begin
                        if (rx != SOCKS_VER) phase_in = PH_DONE;
                        else count_in = 2'd1;
                     end else if (rx != METHOD_NONE) begin
                        phase_in = PH_DONE;
                     end else begin
                        phase_in = PH_HEAD;
                        count_in = '0;
                     end
                  end
                  PH_HEAD: begin
                     if (count_ff == 2'd0) begin
                        if (rx != SOCKS_VER) phase_in = PH_DONE;
                        else count_in = count_ff + 1'b1;
                     end else if (count_ff == 2'd1) begin
                        if (rx != STATUS_OK) phase_in = PH_DONE;
                        else count_in = count_ff + 1'b1;
                     end else if (count_ff == 2'd2) begin
                        if (rx != RSV_BYTE) phase_in = PH_DONE;
                        else count_in = count_ff + 1'b1;
                     end else begin
                        count_in = '0;
                        if (rx == ATYP_IPV4) begin
                           skip_in  = SKIP_IPV4;
                           phase_in = PH_SKIP;
                        end else if (rx == ATYP_IPV6) begin
                           skip_in  = SKIP_IPV6;
                           phase_in = PH_SKIP;
                        end else if (rx == ATYP_NAME) begin
                           phase_in = PH_NAMELEN;
                        end else begin
                           phase_in = PH_DONE;
                        end
                     end
                  end
                  PH_NAMELEN: begin
                     skip_in  = 9'(rx) + PORT_LEN;
                     phase_in = PH_SKIP;
                  end
                  PH_SKIP: begin
                     skip_in = skip_dec;
                     if (skip_dec == '0) phase_in = PH_DONE;
                  end
                  default: begin
                     phase_in = phase_ff;
                  end
               endcase
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // job output: greeting on start, request after method reply, verdict on finish
   always_comb begin
      push                = 1'b0;
      push_job.kind       = JOB_FAIL;
      push_job.family     = family_ff;
      push_job.addr_high  = addr_high_ff;
      push_job.addr_low   = addr_low_ff;
      push_job.port       = port_ff;
      if (fire) begin
         if (req_data.action == ACT_START) begin
            push          = 1'b1;
            push_job.kind = JOB_GREET;
         end else if (phase_ff == PH_METHOD && phase_in == PH_HEAD) begin
            push          = 1'b1;
            push_job.kind = JOB_REQUEST;
         end else if (phase_in == PH_DONE && phase_ff != PH_DONE) begin
            push          = 1'b1;
            push_job.kind = (phase_ff == PH_SKIP && req_data.action == ACT_BYTE)
                            ? JOB_READY : JOB_FAIL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         count_ff  <= '0;
         skip_ff   <= '0;
         family_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         skip_ff  <= skip_in;
         if (fire && req_data.action == ACT_START) begin
            family_ff <= req_data.address_family;
         end
      end
   end

   // saved destination, written on every start
   always_ff @(posedge clock) begin
      if (fire && req_data.action == ACT_START) begin
         addr_high_ff <= req_data.dest_addr_high;
         addr_low_ff  <= req_data.dest_addr_low;
         port_ff      <= req_data.dest_port;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (push && push_job.kind == JOB_REQUEST) |=> (phase_ff == PH_HEAD))
      else $error("request queued without moving to reply header");
   assert property (@(posedge clock) disable iff (reset)
      (fire && req_data.action == ACT_BYTE && !in_hs) |-> !push)
      else $error("byte outside the handshake produced a job");

endmodule

/* hw/rtl/socks_back.sv */
// back end: serializes queued jobs into results, one per unstalled cycle
// depends on socks_pkg for the job type, lengths and byte helper

module socks_back
   import socks_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    q_empty,
   input  job_type q_job,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   job_type    job_ff;
   logic       active_ff, active_in;
   logic [4:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;
   logic       load_ok;
   logic       emit;
   logic       last;

   assign load_ok   = !rsp_valid_ff || rsp_ready;
   assign emit      = active_ff && load_ok;
   assign last      = (idx_ff == job_len(job_ff) - 1'b1);
   assign pop       = !q_empty && (!active_ff || (emit && last));
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // job sequencing
   always_comb begin
      active_in = active_ff;
      idx_in    = idx_ff;
      if (pop) begin
         active_in = 1'b1;
         idx_in    = '0;
      end else if (emit && last) begin
         active_in = 1'b0;
      end else if (emit) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in.last_of_run = last;
         case (job_ff.kind)
            JOB_READY: begin
               rsp_data_in.out_kind = KIND_READY;
               rsp_data_in.tx_byte  = '0;
            end
            JOB_FAIL: begin
               rsp_data_in.out_kind = KIND_FAIL;
               rsp_data_in.tx_byte  = '0;
            end
            default: begin
               rsp_data_in.out_kind = KIND_TX;
               rsp_data_in.tx_byte  = job_byte(job_ff, idx_ff);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (pop) begin
         job_ff <= q_job;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (idx_ff < job_len(job_ff)))
      else $error("byte index past the end of the job");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.out_kind != KIND_TX) |->
      (rsp_data.last_of_run && rsp_data.tx_byte == '0))
      else $error("verdict transaction not a single zero-byte run");

endmodule

/* hw/rtl/socks5_client_connect_handshake_core.sv */
// top level of the socks5 no-auth connect handshake client core
// depends on socks_pkg, socks_front, socks_queue and socks_back
//
//   channel  direction  handshake              payload
//   req_     in         req_valid / req_ready  req_type: action, family, address, port, byte
//   rsp_     out        rsp_valid / rsp_ready  rsp_type: out_kind, tx_byte, last_of_run
//
// the front accepts one request transaction per cycle while the job queue has room
// the back emits one result per cycle when not stalled; start 3, request 10 or 22, verdict 1
// request bursts are bounded by the back's one-byte-per-cycle serializer and by rsp_ready
// reset (synchronous) clears phase, queue and output valid; saved destination is not cleared
// a stalled rsp_ready fills the queue, after which req_ready drops

module socks5_client_connect_handshake_core
   import socks_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    push;
   logic    pop;
   logic    q_full;
   logic    q_empty;
   job_type push_job;
   job_type pop_job;

   // protocol checker and job producer
   socks_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .push      (push),
      .push_job  (push_job),
      .q_full    (q_full)
   );

   // decoupling queue
   socks_queue #(
      .DEPTH (DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (pop),
      .pop_job  (pop_job),
      .empty    (q_empty)
   );

   // result serializer
   socks_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_job     (pop_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* tb/tb_socks5_client_connect_handshake_core.sv */
// self-checking testbench for the socks5 no-auth connect handshake client core
// depends on socks_pkg and socks5_client_connect_handshake_core; models the handshake in-line

`timescale 1ns / 100ps

module tb_socks5_client_connect_handshake_core;
   import socks_pkg::*;

   // action code the block leaves unused
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   // ways a random handshake gets broken
   localparam int FAULT_BYTE    = 0;
   localparam int FAULT_CLOSE   = 1;
   localparam int FAULT_UNUSED  = 2;
   localparam int FAULT_RESTART = 3;
   localparam int FAULT_ATYP    = 4;

   // position of the address type byte in a handshake script
   localparam int ATYP_POS = 6;

   localparam int LONG_HOLD    = 200;
   localparam int DRAIN_CYCLES = 50;
   localparam int CYCLE_LIMIT  = 200000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // model of the client handshake
   phase_type   hs_phase = PH_IDLE;
   logic [7:0]  hs_count = '0;
   logic [8:0]  hs_skip = '0;
   logic        dst_family = 1'b0;
   logic [63:0] dst_high = '0;
   logic [63:0] dst_low = '0;
   logic [15:0] dst_port = '0;

   rsp_type run_buf[$];
   rsp_type handshake_out_q[$];
   req_type script[$];

   bit idle_enable = 1'b1;
   int long_hold = 0;
   int ready_gap = 0;
   int cycle_count = 0;
   int items_sent = 0;
   int results_checked = 0;
   int mismatches = 0;
   int tunnels_ready = 0;
   int handshakes_failed = 0;

   socks5_client_connect_handshake_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // clock generation
   initial clock = 1'b0;
   always #2 clock = ~clock;

   // run watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  handshake_out_q.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // append one result to the run being built
   task automatic push_result(input logic [1:0] kind, input logic [7:0] value);
      rsp_type r;
      r.out_kind    = kind;
      r.tx_byte     = value;
      r.last_of_run = 1'b0;
      run_buf.push_back(r);
   endtask

   // ready or failed verdict ends the handshake
   task automatic give_verdict(input logic [1:0] kind);
      hs_phase = PH_DONE;
      push_result(kind, 8'd0);
      if (kind == KIND_READY) tunnels_ready++;
      else handshakes_failed++;
   endtask

   // connect request in network order
   task automatic push_request();
      int i;
      push_result(KIND_TX, SOCKS_VER);
      push_result(KIND_TX, CMD_CONNECT);
      push_result(KIND_TX, RSV_BYTE);
      if (!dst_family) begin
         push_result(KIND_TX, ATYP_IPV4);
         for (i = 3; i >= 0; i--) push_result(KIND_TX, dst_low[8*i +: 8]);
      end else begin
         push_result(KIND_TX, ATYP_IPV6);
         for (i = 7; i >= 0; i--) push_result(KIND_TX, dst_high[8*i +: 8]);
         for (i = 7; i >= 0; i--) push_result(KIND_TX, dst_low[8*i +: 8]);
      end
      push_result(KIND_TX, dst_port[15:8]);
      push_result(KIND_TX, dst_port[7:0]);
   endtask

   // advance the handshake model by one accepted transaction
   task automatic step_handshake(input req_type item);
      logic [7:0] b;
      rsp_type    r;
      b = item.rx_byte;
      run_buf.delete();
      case (item.action)
         ACT_START: begin
            dst_family = item.address_family;
            dst_high   = item.dest_addr_high;
            dst_low    = item.dest_addr_low;
            dst_port   = item.dest_port;
            hs_phase   = PH_METHOD;
            hs_count   = '0;
            hs_skip    = '0;
            push_result(KIND_TX, SOCKS_VER);
            push_result(KIND_TX, NUM_METHODS);
            push_result(KIND_TX, METHOD_NONE);
         end
         ACT_CLOSE: begin
            if (hs_phase != PH_IDLE && hs_phase != PH_DONE) give_verdict(KIND_FAIL);
         end
         ACT_BYTE: begin
            case (hs_phase)
               PH_METHOD: begin
                  if (hs_count == 0) begin
                     if (b != SOCKS_VER) give_verdict(KIND_FAIL);
                     else hs_count = 8'd1;
                  end else if (b != METHOD_NONE) begin
                     give_verdict(KIND_FAIL);
                  end else begin
                     hs_phase = PH_HEAD;
                     hs_count = '0;
                     push_request();
                  end
               end
               PH_HEAD: begin
                  if (hs_count == 0) begin
                     if (b != SOCKS_VER) give_verdict(KIND_FAIL);
                     else hs_count++;
                  end else if (hs_count == 1) begin
                     if (b != STATUS_OK) give_verdict(KIND_FAIL);
                     else hs_count++;
                  end else if (hs_count == 2) begin
                     if (b != RSV_BYTE) give_verdict(KIND_FAIL);
                     else hs_count++;
                  end else begin
                     // address type picks how much of the bound address to skip
                     hs_count = '0;
                     if (b == ATYP_IPV4) begin
                        hs_skip  = SKIP_IPV4;
                        hs_phase = PH_SKIP;
                     end else if (b == ATYP_IPV6) begin
                        hs_skip  = SKIP_IPV6;
                        hs_phase = PH_SKIP;
                     end else if (b == ATYP_NAME) begin
                        hs_phase = PH_NAMELEN;
                     end else begin
                        give_verdict(KIND_FAIL);
                     end
                  end
               end
               PH_NAMELEN: begin
                  hs_skip  = {1'b0, b} + PORT_LEN;
                  hs_phase = PH_SKIP;
               end
               PH_SKIP: begin
                  if (hs_skip > 0) hs_skip--;
                  if (hs_skip == 0) give_verdict(KIND_READY);
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      // flag the last result of the run and queue the run
      if (run_buf.size() > 0) begin
         r = run_buf.pop_back();
         r.last_of_run = 1'b1;
         run_buf.push_back(r);
      end
      foreach (run_buf[i]) handshake_out_q.push_back(run_buf[i]);
   endtask

   // prediction on accepted requests, comparison on accepted results
   always @(posedge clock) begin : scoreboard
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) step_handshake(req_data);
         if (rsp_valid && rsp_ready) begin
            if (handshake_out_q.size() == 0) begin
               $error("result with nothing expected: kind %0d byte %0d last %0d",
                      rsp_data.out_kind, rsp_data.tx_byte, rsp_data.last_of_run);
               mismatches++;
            end else begin
               want = handshake_out_q.pop_front();
               results_checked++;
               if (rsp_data.out_kind !== want.out_kind) begin
                  $error("out_kind expected %0d actual %0d", want.out_kind, rsp_data.out_kind);
                  mismatches++;
               end
               if (rsp_data.tx_byte !== want.tx_byte) begin
                  $error("tx_byte expected %0d actual %0d", want.tx_byte, rsp_data.tx_byte);
                  mismatches++;
               end
               if (rsp_data.last_of_run !== want.last_of_run) begin
                  $error("last_of_run expected %0d actual %0d", want.last_of_run,
                         rsp_data.last_of_run);
                  mismatches++;
               end
            end
         end
      end
   end

   // result side: random stall bursts and one long hold on request
   always @(posedge clock) begin
      if (long_hold > 0) begin
         rsp_ready <= 1'b0;
         long_hold--;
      end else if (ready_gap > 0) begin
         rsp_ready <= 1'b0;
         ready_gap--;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         ready_gap = $urandom_range(0, 3);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic req_type random_item(input logic [1:0] act);
      req_type item;
      item.action         = act;
      item.address_family = 1'($urandom_range(0, 1));
      item.dest_addr_high = {$urandom, $urandom};
      item.dest_addr_low  = {$urandom, $urandom};
      item.dest_port      = 16'($urandom_range(0, 65535));
      item.rx_byte        = 8'($urandom_range(0, 255));
      return item;
   endfunction

   function automatic req_type byte_item(input logic [7:0] value);
      req_type item;
      item         = random_item(ACT_BYTE);
      item.rx_byte = value;
      return item;
   endfunction

   function automatic req_type start_item(input logic family, input logic [63:0] high,
                                          input logic [63:0] low, input logic [15:0] port);
      req_type item;
      item                = random_item(ACT_START);
      item.address_family = family;
      item.dest_addr_high = high;
      item.dest_addr_low  = low;
      item.dest_port      = port;
      return item;
   endfunction

   // offer one transaction and wait until it is taken
   task automatic send_item(input req_type item);
      if (idle_enable && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (item.action != ACT_UNUSED) items_sent++;
   endtask

   task automatic send_script();
      foreach (script[i]) send_item(script[i]);
   endtask

   // stop offering and wait for every expected result, then let the block settle
   task automatic wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (handshake_out_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one random handshake script, well formed or broken at a random point
   task automatic build_handshake(input bit broken);
      logic [7:0] atyp;
      int         name_len;
      int         bound_len;
      int         cut;
      int         fault;
      script.delete();
      name_len = 0;
      script.push_back(random_item(ACT_START));
      script.push_back(byte_item(SOCKS_VER));
      script.push_back(byte_item(METHOD_NONE));
      script.push_back(byte_item(SOCKS_VER));
      script.push_back(byte_item(STATUS_OK));
      script.push_back(byte_item(RSV_BYTE));
      case ($urandom_range(0, 2))
         0: begin
            atyp      = ATYP_IPV4;
            bound_len = SKIP_IPV4;
         end
         1: begin
            atyp      = ATYP_IPV6;
            bound_len = SKIP_IPV6;
         end
         default: begin
            atyp      = ATYP_NAME;
            name_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40)
                                                    : $urandom_range(0, 6);
            bound_len = name_len + PORT_LEN;
         end
      endcase
      script.push_back(byte_item(atyp));
      if (atyp == ATYP_NAME) script.push_back(byte_item(name_len[7:0]));
      repeat (bound_len) script.push_back(byte_item(8'($urandom_range(0, 255))));
      if (!broken) begin
         // trailing traffic after the verdict is ignored
         if ($urandom_range(0, 3) == 0)
            script.push_back(random_item($urandom_range(0, 1) ? ACT_BYTE : ACT_CLOSE));
      end else begin
         fault = $urandom_range(FAULT_BYTE, FAULT_ATYP);
         cut   = (fault == FAULT_ATYP) ? ATYP_POS : $urandom_range(1, script.size() - 1);
         while (script.size() > cut) void'(script.pop_back());
         case (fault)
            FAULT_BYTE:    script.push_back(byte_item(8'($urandom_range(0, 255))));
            FAULT_CLOSE:   script.push_back(random_item(ACT_CLOSE));
            FAULT_UNUSED:  script.push_back(random_item(ACT_UNUSED));
            FAULT_RESTART: script.push_back(random_item(ACT_START));
            default: begin
               atyp = 8'($urandom_range(0, 255));
               while (atyp == ATYP_IPV4 || atyp == ATYP_IPV6 || atyp == ATYP_NAME)
                  atyp = 8'($urandom_range(0, 255));
               script.push_back(byte_item(atyp));
            end
         endcase
      end
   endtask

   // bytes, closes and unused codes before any start
   task automatic test_idle_ignores();
      send_item(byte_item(SOCKS_VER));
      send_item(random_item(ACT_CLOSE));
      send_item(random_item(ACT_UNUSED));
   endtask

   // ipv4 request with the widest fields; upper address bits must not leak
   task automatic test_ipv4_request();
      send_item(start_item(1'b0, '1, '1, 16'hFFFF));
      send_item(byte_item(SOCKS_VER));
      send_item(byte_item(METHOD_NONE));
   endtask

   // ipv6 request with zero upper half and port zero
   task automatic test_ipv6_request();
      send_item(start_item(1'b1, '0, '1, 16'h0000));
      send_item(byte_item(SOCKS_VER));
      send_item(byte_item(METHOD_NONE));
   endtask

   // bad method reply bytes, then traffic after the failure
   task automatic test_method_errors();
      send_item(random_item(ACT_START));
      send_item(byte_item(8'd4));
      send_item(byte_item(SOCKS_VER));
      send_item(random_item(ACT_CLOSE));
      send_item(random_item(ACT_START));
      send_item(byte_item(SOCKS_VER));
      send_item(byte_item(8'hFF));
   endtask

   // link closed in the middle of the handshake
   task automatic test_close_mid_handshake();
      send_item(random_item(ACT_START));
      send_item(byte_item(SOCKS_VER));
      send_item(random_item(ACT_CLOSE));
   endtask

   // a new start in the middle restarts from the greeting
   task automatic test_restart();
      send_item(start_item(1'b1, {$urandom, $urandom}, {$urandom, $urandom}, 16'h1234));
      send_item(byte_item(SOCKS_VER));
      send_item(start_item(1'b0, {$urandom, $urandom}, {$urandom, $urandom}, 16'h8001));
      send_item(byte_item(SOCKS_VER));
      send_item(byte_item(METHOD_NONE));
   endtask

   // result side holds off long while starts keep coming, so the queue fills
   task automatic test_backpressure();
      long_hold = LONG_HOLD;
      repeat (10) send_item(random_item(ACT_START));
      wait_drain();
   endtask

   // random handshakes, mostly well formed, until n more transactions went in
   task automatic test_random_handshakes(input int n);
      int stop_at;
      stop_at = items_sent + n;
      while (items_sent < stop_at) begin
         build_handshake($urandom_range(0, 9) < 3);
         send_script();
      end
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_ready = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_idle_ignores();
      test_ipv4_request();
      test_ipv6_request();
      test_method_errors();
      test_close_mid_handshake();
      test_restart();
      wait_drain();

      test_backpressure();

      test_random_handshakes(205);
      wait_drain();

      // closing stretch with the result side always ready and no request gaps
      idle_enable = 1'b0;
      test_random_handshakes(55);
      wait_drain();

      $display("sent %0d transactions, checked %0d results", items_sent, results_checked);
      $display("handshakes ended ready %0d times and failed %0d times",
               tunnels_ready, handshakes_failed);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
